// ===== rtl/circular_deque_macros.svh =====
// ----------------------------------------------------------------------------
// circular_deque_macros.svh
// Assertion macros shared by the deque checker.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_DEQUE_MACROS_SVH
`define CIRCULAR_DEQUE_MACROS_SVH

// Same-cycle implication, skipped while reset is low.
`define CDQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, skipped while reset is low.
`define CDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/cdq_pkg.sv =====
// ----------------------------------------------------------------------------
// cdq_pkg
// Request and result types, command and status codes, controller states.
// ----------------------------------------------------------------------------
package cdq_pkg;

    localparam int FIELD_W = 32;
    localparam int EXT_W   = 64;

    localparam logic [2:0] CMD_NOP        = 3'd0;
    localparam logic [2:0] CMD_PUSH_FRONT = 3'd1;
    localparam logic [2:0] CMD_PUSH_REAR  = 3'd2;
    localparam logic [2:0] CMD_POP_FRONT  = 3'd3;
    localparam logic [2:0] CMD_POP_REAR   = 3'd4;

    localparam logic [1:0] STS_DONE  = 2'd0;
    localparam logic [1:0] STS_FULL  = 2'd1;
    localparam logic [1:0] STS_EMPTY = 2'd2;

    typedef struct packed {
        logic [2:0]                cmd;
        logic signed [FIELD_W-1:0] push_value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]                status;
        logic signed [FIELD_W-1:0] front_value;
        logic signed [FIELD_W-1:0] rear_value;
        logic                      empty_flag;
        logic                      full_flag;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic capture;
        logic execute;
        logic read;
        logic load;
    } t_dp_cmd;

endpackage

// ===== rtl/cdq_ctrl.sv =====
// ----------------------------------------------------------------------------
// cdq_ctrl
// Sequencer: accept a request, update, read both ends, load the result.
// ----------------------------------------------------------------------------
module cdq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output cdq_pkg::t_dp_cmd o_dp_cmd
);

    cdq_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;
    logic            w_load_ok;

    assign w_load_ok = !r_out_valid || !i_out_stall;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cdq_pkg::ST_IDLE: if (i_in_valid) n_state = cdq_pkg::ST_EXEC;
            cdq_pkg::ST_EXEC: n_state = cdq_pkg::ST_READ;
            cdq_pkg::ST_READ: n_state = cdq_pkg::ST_DONE;
            cdq_pkg::ST_DONE: if (w_load_ok) n_state = cdq_pkg::ST_IDLE;
            default:          n_state = cdq_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_dp_cmd   = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            cdq_pkg::ST_IDLE: begin
                o_in_stall       = 1'b0;
                o_dp_cmd.capture = i_in_valid;
            end
            cdq_pkg::ST_EXEC: o_dp_cmd.execute = 1'b1;
            cdq_pkg::ST_READ: o_dp_cmd.read    = 1'b1;
            cdq_pkg::ST_DONE: o_dp_cmd.load    = w_load_ok;
            default:          o_dp_cmd         = '0;
        endcase
    end

    // result valid: set on load, drop once taken
    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        if (o_dp_cmd.load) n_out_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cdq_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/cdq_dpath.sv =====
// ----------------------------------------------------------------------------
// cdq_dpath
// Ring store, head and tail indices, empty mark and the result register.
// ----------------------------------------------------------------------------
module cdq_dpath #(
    parameter int DEPTH      = 128,
    parameter int WORD_WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cdq_pkg::t_dp_cmd  i_dp_cmd,
    input  cdq_pkg::t_in_item i_in_data,
    output cdq_pkg::t_out_item o_out_data
);

    localparam int               IDX_W    = $clog2(DEPTH);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);

    function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] i);
        return (i == IDX_LAST) ? '0 : i + IDX_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] i);
        return (i == '0) ? IDX_LAST : i - IDX_W'(1);
    endfunction

    logic [WORD_WIDTH-1:0] mem [DEPTH];

    logic [2:0]            r_cmd;
    logic [WORD_WIDTH-1:0] r_word;
    logic [IDX_W-1:0]      r_head, n_head;
    logic [IDX_W-1:0]      r_tail, n_tail;
    logic                  r_vacant, n_vacant;
    logic [1:0]            r_status, n_status;
    logic [WORD_WIDTH-1:0] r_front_rd, r_rear_rd;
    cdq_pkg::t_out_item    r_out;

    logic                  w_full;
    logic                  w_wr_en;
    logic [IDX_W-1:0]      w_wr_addr;
    logic [cdq_pkg::EXT_W-1:0] w_in_ext, w_front_ext, w_rear_ext;

    assign w_full   = !r_vacant && (idx_next(r_tail) == r_head);
    assign w_in_ext = {{(cdq_pkg::EXT_W - cdq_pkg::FIELD_W){1'b0}}, i_in_data.push_value};

    // command decode and index update
    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        n_vacant  = r_vacant;
        n_status  = cdq_pkg::STS_DONE;
        w_wr_en   = 1'b0;
        w_wr_addr = '0;
        case (r_cmd) inside
            cdq_pkg::CMD_PUSH_FRONT, cdq_pkg::CMD_PUSH_REAR: begin
                if (w_full) begin
                    n_status = cdq_pkg::STS_FULL;
                end else if (r_vacant) begin
                    n_head   = '0;
                    n_tail   = '0;
                    n_vacant = 1'b0;
                    w_wr_en  = 1'b1;
                end else if (r_cmd == cdq_pkg::CMD_PUSH_FRONT) begin
                    n_head    = idx_prev(r_head);
                    w_wr_addr = n_head;
                    w_wr_en   = 1'b1;
                end else begin
                    n_tail    = idx_next(r_tail);
                    w_wr_addr = n_tail;
                    w_wr_en   = 1'b1;
                end
            end
            cdq_pkg::CMD_POP_FRONT, cdq_pkg::CMD_POP_REAR: begin
                if (r_vacant) begin
                    n_status = cdq_pkg::STS_EMPTY;
                end else if (r_head == r_tail) begin
                    n_head   = '0;
                    n_tail   = '0;
                    n_vacant = 1'b1;
                end else if (r_cmd == cdq_pkg::CMD_POP_FRONT) begin
                    n_head = idx_next(r_head);
                end else begin
                    n_tail = idx_prev(r_tail);
                end
            end
            default: n_status = cdq_pkg::STS_DONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_tail   <= '0;
            r_vacant <= 1'b1;
        end else if (i_dp_cmd.execute) begin
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_vacant <= n_vacant;
        end
    end

    // request capture and status hold
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.capture) begin
            r_cmd  <= i_in_data.cmd;
            r_word <= w_in_ext[WORD_WIDTH-1:0];
        end
        if (i_dp_cmd.execute) r_status <= n_status;
    end

    // ring store: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.execute && w_wr_en) mem[w_wr_addr] <= r_word;
        if (i_dp_cmd.read) begin
            r_front_rd <= mem[r_head];
            r_rear_rd  <= mem[r_tail];
        end
    end

    assign w_front_ext = cdq_pkg::EXT_W'(r_front_rd);
    assign w_rear_ext  = cdq_pkg::EXT_W'(r_rear_rd);

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load) begin
            r_out.status      <= r_status;
            r_out.front_value <= r_vacant ? '0 : w_front_ext[cdq_pkg::FIELD_W-1:0];
            r_out.rear_value  <= r_vacant ? '0 : w_rear_ext[cdq_pkg::FIELD_W-1:0];
            r_out.empty_flag  <= r_vacant;
            r_out.full_flag   <= w_full;
        end
    end

    assign o_out_data = r_out;

endmodule

// ===== rtl/circular_deque.sv =====
// ----------------------------------------------------------------------------
// circular_deque
// Double-ended queue in a ring store with push/pop at either end.
// ----------------------------------------------------------------------------
// A request is captured, then applied to the indices and store, then both ends are
// read into registers, then the result is loaded; the load waits while an earlier
// result is still stalled. No new request is taken before the last one is loaded.
// A waiting result is held in its own register, so the next request is taken meanwhile.
// Reset (synchronous, active low) empties the queue at once; no clearing pass.
module circular_deque #(
    parameter int DEPTH      = 128,
    parameter int WORD_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  cdq_pkg::t_in_item  i_in_data,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output cdq_pkg::t_out_item o_out_data
);

    // Command bundle from the sequencer into the datapath: capture the
    // request, execute it on the indices and store, read both ends, load
    // the result register.
    cdq_pkg::t_dp_cmd w_dp_cmd;

    // Sequencer: owns both handshakes and steps one request at a time.
    cdq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_dp_cmd    (w_dp_cmd)
    );

    // Datapath: ring store, indices, empty mark and result register.
    // Refused pushes and pops leave the indices alone and only set status.
    cdq_dpath #(
        .DEPTH      (DEPTH),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_dp_cmd   (w_dp_cmd),
        .i_in_data  (i_in_data),
        .o_out_data (o_out_data)
    );

endmodule

// ===== rtl/cdq_checker.sv =====
// ----------------------------------------------------------------------------
// cdq_port_checks
// Port-level checks on results of the deque, bound to the top level.
// ----------------------------------------------------------------------------
`include "circular_deque_macros.svh"

module cdq_port_checks (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_stall,
    input cdq_pkg::t_out_item i_out_data
);

    `CDQ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && i_out_stall,
        i_out_valid && $stable(i_out_data), "stalled result changed")
    `CDQ_ASSERT_NOW(a_flags_excl, i_clk, i_rst_n, i_out_valid,
        !(i_out_data.empty_flag && i_out_data.full_flag), "queue both empty and full")
    `CDQ_ASSERT_NOW(a_empty_zero, i_clk, i_rst_n, i_out_valid && i_out_data.empty_flag,
        i_out_data.front_value == '0 && i_out_data.rear_value == '0, "empty queue shows data")
    `CDQ_ASSERT_NOW(a_refused_full, i_clk, i_rst_n,
        i_out_valid && i_out_data.status == cdq_pkg::STS_FULL,
        i_out_data.full_flag, "push refused while not full")
    `CDQ_ASSERT_NOW(a_refused_empty, i_clk, i_rst_n,
        i_out_valid && i_out_data.status == cdq_pkg::STS_EMPTY,
        i_out_data.empty_flag, "pop refused while not empty")

endmodule

bind circular_deque cdq_port_checks u_cdq_port_checks (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_data  (o_out_data)
);

// ===== bench/cdq_checker.sv =====
// ----------------------------------------------------------------------------
// cdq_checker
// Watches both deque channels, predicts each result and compares it.
// ----------------------------------------------------------------------------
module cdq_checker
    import cdq_pkg::*;
#(
    parameter int DEPTH      = 128,
    parameter int WORD_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_item  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_item i_out_data,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_full_refusals,
    output int        o_empty_refusals
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [FIELD_W-1:0] WORD_MASK = (WORD_WIDTH >= FIELD_W) ? {FIELD_W{1'b1}} :
        FIELD_W'((64'd1 << WORD_WIDTH) - 64'd1);

    // shadow copy of the deque
    logic [FIELD_W-1:0] ring_words [DEPTH];
    logic [IDX_W-1:0]   head_pos;
    logic [IDX_W-1:0]   tail_pos;
    logic               ring_vacant;

    t_out_item expected_results [$];

    function automatic logic [IDX_W-1:0] step_up(input logic [IDX_W-1:0] pos);
        return (pos == IDX_W'(DEPTH - 1)) ? '0 : pos + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] step_down(input logic [IDX_W-1:0] pos);
        return (pos == '0) ? IDX_W'(DEPTH - 1) : pos - 1'b1;
    endfunction

    function automatic logic ring_full();
        return !ring_vacant && (step_up(tail_pos) == head_pos);
    endfunction

    // Apply one request to the shadow deque and build the result it yields.
    task automatic apply_request(input t_in_item req, output t_out_item res);
        logic [1:0]         sts;
        logic [FIELD_W-1:0] word;
        sts  = STS_DONE;
        word = req.push_value & WORD_MASK;
        case (req.cmd)
            CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
                if (ring_full()) begin
                    sts = STS_FULL;
                end else if (ring_vacant) begin
                    head_pos      = '0;
                    tail_pos      = '0;
                    ring_vacant   = 1'b0;
                    ring_words[0] = word;
                end else if (req.cmd == CMD_PUSH_FRONT) begin
                    head_pos             = step_down(head_pos);
                    ring_words[head_pos] = word;
                end else begin
                    tail_pos             = step_up(tail_pos);
                    ring_words[tail_pos] = word;
                end
            end
            CMD_POP_FRONT, CMD_POP_REAR: begin
                if (ring_vacant) begin
                    sts = STS_EMPTY;
                end else if (head_pos == tail_pos) begin
                    head_pos    = '0;
                    tail_pos    = '0;
                    ring_vacant = 1'b1;
                end else if (req.cmd == CMD_POP_FRONT) begin
                    head_pos = step_up(head_pos);
                end else begin
                    tail_pos = step_down(tail_pos);
                end
            end
            default: begin
            end
        endcase
        res.status      = sts;
        res.empty_flag  = ring_vacant;
        res.full_flag   = ring_full();
        res.front_value = ring_vacant ? '0 : ring_words[head_pos];
        res.rear_value  = ring_vacant ? '0 : ring_words[tail_pos];
    endtask

    task automatic check_field(input string name, input logic [FIELD_W-1:0] want,
                               input logic [FIELD_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item predicted;
        t_out_item want;
        if (!i_rst_n) begin
            head_pos    = '0;
            tail_pos    = '0;
            ring_vacant = 1'b1;
            expected_results.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                apply_request(i_in_data, predicted);
                expected_results.push_back(predicted);
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result arrived with no request outstanding");
                    o_fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", FIELD_W'(want.status), FIELD_W'(i_out_data.status));
                    check_field("empty_flag", FIELD_W'(want.empty_flag),
                                FIELD_W'(i_out_data.empty_flag));
                    check_field("full_flag", FIELD_W'(want.full_flag),
                                FIELD_W'(i_out_data.full_flag));
                    // end words carry meaning only while something is queued
                    if (!want.empty_flag) begin
                        check_field("front_value", want.front_value, i_out_data.front_value);
                        check_field("rear_value", want.rear_value, i_out_data.rear_value);
                    end
                end
                if (i_out_data.status == STS_FULL) o_full_refusals++;
                if (i_out_data.status == STS_EMPTY) o_empty_refusals++;
            end
        end
        o_pending = expected_results.size();
    end

endmodule

// ===== bench/tb_circular_deque.sv =====
// ----------------------------------------------------------------------------
// tb_circular_deque
// Drives directed and random deque requests with random idle and stall
// bursts; a checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_circular_deque;
    timeunit 1ns;
    timeprecision 1ps;

    import cdq_pkg::*;

    localparam int DEPTH           = 128;
    localparam int WORD_WIDTH      = 32;
    localparam int RANDOM_REQUESTS = 1350;
    localparam int QUIET_TAIL      = 150;  // last requests run with no idling at all
    localparam int DRAIN_CYCLES    = 12;   // spare room after the drain for any stray result
    localparam int WATCHDOG_LIMIT  = 500;

    // command codes the block must treat as no-ops
    localparam logic [2:0] CMD_SPARE_5 = 3'd5;
    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;

    // request mix of one random segment
    typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} t_mix;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_data   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_data;

    int fail_count;
    int pending;
    int full_refusals;
    int empty_refusals;

    int n_push;
    int n_pop;
    int n_noop;
    int in_gap_pct    = 0;
    int out_stall_pct = 0;
    int stall_run     = 0;
    int idle_cycles   = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    circular_deque #(
        .DEPTH      (DEPTH),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    cdq_checker #(
        .DEPTH      (DEPTH),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_in_data        (i_in_data),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_out_data       (o_out_data),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_full_refusals  (full_refusals),
        .o_empty_refusals (empty_refusals)
    );

    // Result side: stall in random-length bursts that never follow one another back
    // to back. A zero rate turns stalling off.
    always @(negedge i_clk) begin
        if (stall_run > 0) begin
            stall_run = stall_run - 1;
        end else if (out_stall_pct > 0 && $urandom_range(1, 100) <= out_stall_pct) begin
            stall_run = $urandom_range(1, 9);
        end
        i_out_stall = (stall_run > 0);
    end

    // Watchdog: count cycles in which neither channel completes a handshake.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("circular_deque regression: fail");
            $finish;
        end
    end

    // Present one request at a falling edge, optionally after an idle burst,
    // and hold it until a rising edge sees it taken. Valid stays high into
    // the next request unless that one opens with a gap.
    task automatic send_request(input logic [2:0] cmd, input logic [FIELD_W-1:0] value);
        if (in_gap_pct > 0 && $urandom_range(1, 100) <= in_gap_pct) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        i_in_data.cmd        = cmd;
        i_in_data.push_value = value;
        i_in_valid           = 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        case (cmd)
            CMD_PUSH_FRONT, CMD_PUSH_REAR: n_push++;
            CMD_POP_FRONT, CMD_POP_REAR:   n_pop++;
            default:                       n_noop++;
        endcase
        @(negedge i_clk);
    endtask

    // Drop valid and hold off until every outstanding result has come back.
    task automatic settle();
        i_in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    initial begin
        t_mix       mix;
        int         seg;
        int         seg_len;
        int         counted;
        int         pick;
        logic [2:0] cmd;

        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed opening: pops and no-op on the fresh queue, pushes into
        // empty at both ends, head wrap below slot zero, spare codes, popping
        // the last entry from either end, and extreme data words.
        send_request(CMD_NOP, 32'h0000_0000);
        send_request(CMD_POP_FRONT, 32'hFFFF_FFFF);
        send_request(CMD_POP_REAR, 32'h0000_0000);
        send_request(CMD_PUSH_FRONT, 32'h8000_0000);
        send_request(CMD_PUSH_REAR, 32'h7FFF_FFFF);
        send_request(CMD_PUSH_FRONT, 32'hFFFF_FFFF);
        send_request(CMD_PUSH_REAR, 32'h0000_0000);
        send_request(CMD_SPARE_5, 32'hDEAD_BEEF);
        send_request(CMD_SPARE_6, 32'h1234_5678);
        send_request(CMD_SPARE_7, 32'hFFFF_FFFF);
        send_request(CMD_POP_FRONT, 32'h0000_0000);
        send_request(CMD_POP_REAR, 32'h0000_0000);
        send_request(CMD_POP_FRONT, 32'h0000_0000);
        send_request(CMD_POP_REAR, 32'h0000_0000);
        send_request(CMD_POP_REAR, 32'h0000_0000);
        send_request(CMD_PUSH_REAR, 32'h5555_5555);
        send_request(CMD_POP_FRONT, 32'h0000_0000);
        send_request(CMD_PUSH_REAR, 32'hAAAA_AAAA);
        send_request(CMD_PUSH_FRONT, 32'h0000_0001);
        send_request(CMD_NOP, 32'h8000_0000);
        send_request(CMD_POP_REAR, 32'h0000_0000);
        send_request(CMD_POP_REAR, 32'h0000_0000);
        settle();

        // Random segments cycle fill, even, drain, even. Fill and drain are
        // long enough to run the ring from empty to full (with refused pushes)
        // and back (with refused pops). Each segment gets its own idle rates,
        // zero included, so some stretches run back to back.
        counted = 0;
        seg     = 0;
        while (counted < RANDOM_REQUESTS) begin
            mix = (seg % 2 == 1) ? MIX_EVEN : ((seg % 4 == 0) ? MIX_FILL : MIX_DRAIN);
            seg_len = (mix == MIX_EVEN) ? $urandom_range(60, 150) : $urandom_range(200, 300);
            in_gap_pct    = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
            out_stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
            repeat (seg_len) begin
                if (counted >= RANDOM_REQUESTS) break;
                if (RANDOM_REQUESTS - counted <= QUIET_TAIL) begin
                    in_gap_pct    = 0;
                    out_stall_pct = 0;
                end
                pick = $urandom_range(0, 99);
                case (mix)
                    MIX_FILL: begin
                        if (pick < 46)      cmd = CMD_PUSH_FRONT;
                        else if (pick < 92) cmd = CMD_PUSH_REAR;
                        else if (pick < 94) cmd = CMD_POP_FRONT;
                        else if (pick < 96) cmd = CMD_POP_REAR;
                        else                cmd = CMD_NOP;
                    end
                    MIX_DRAIN: begin
                        if (pick < 46)      cmd = CMD_POP_FRONT;
                        else if (pick < 92) cmd = CMD_POP_REAR;
                        else if (pick < 94) cmd = CMD_PUSH_FRONT;
                        else if (pick < 96) cmd = CMD_PUSH_REAR;
                        else                cmd = CMD_NOP;
                    end
                    default: begin
                        if (pick < 22)      cmd = CMD_PUSH_FRONT;
                        else if (pick < 44) cmd = CMD_PUSH_REAR;
                        else if (pick < 66) cmd = CMD_POP_FRONT;
                        else if (pick < 88) cmd = CMD_POP_REAR;
                        else                cmd = CMD_NOP;
                    end
                endcase
                // spread the noise over the no-op and every spare code
                if (cmd == CMD_NOP) begin
                    case ($urandom_range(0, 3))
                        0:       cmd = CMD_NOP;
                        1:       cmd = CMD_SPARE_5;
                        2:       cmd = CMD_SPARE_6;
                        default: cmd = CMD_SPARE_7;
                    endcase
                end
                counted++;
                send_request(cmd, $urandom);
            end
            // now and then hold the sender until the pipeline is empty
            if ($urandom_range(0, 2) == 0) settle();
            seg++;
        end

        // wrap up: drain, then leave room for any stray result
        settle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("covered %0d requests: %0d pushes, %0d pops, %0d no-op or spare codes",
                 n_push + n_pop + n_noop, n_push, n_pop, n_noop);
        $display("refusals seen: %0d pushes into a full ring, %0d pops from an empty one",
                 full_refusals, empty_refusals);
        if (fail_count == 0) begin
            $display("circular_deque regression: pass");
        end else begin
            $display("circular_deque regression: fail");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/cdq_pkg.sv
rtl/cdq_ctrl.sv
rtl/cdq_dpath.sv
rtl/circular_deque.sv
rtl/cdq_checker.sv
bench/cdq_checker.sv
bench/tb_circular_deque.sv
